>>> rtl/core/rpa_pkg.sv
// Shared types, codes and defaults for the refcounted page allocator.
package rpa_pkg;

    localparam int ADDR_W        = 40;
    localparam int CNT_VAL_W     = 8;
    localparam int NUM_PAGES_DEF = 32768;
    localparam int PAGE_BITS_DEF = 12;

    localparam logic [ADDR_W-1:0] BASE_RST   = 40'h00_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_RST    = 40'h00_8800_0000;
    localparam logic [ADDR_W-1:0] USABLE_RST = 40'h00_8002_0000;

    localparam logic [CNT_VAL_W-1:0] CNT_MAX = 8'hFF;

    // register indexes on the config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE = 2'd2;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_ADD_REF = 2'd2,
        FN_READ    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_PAGES  = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_SATURATED = 3'd4
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] usable;
    } t_region;

    typedef struct packed {
        logic [ADDR_W-1:0]    page_address;
        logic [CNT_VAL_W-1:0] ref_value;
        logic                 page_freed;
        t_status              status;
    } t_rsp;

endpackage

>>> rtl/core/rpa_if.sv
// Handshake channel interfaces: request, response and config write.
interface rpa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [39:0] address;

    modport source (output valid, output func, output address, input ready);
    modport sink   (input valid, input func, input address, output ready);
endinterface

interface rpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [39:0] page_address;
    logic [7:0]  ref_value;
    logic        page_freed;
    logic [2:0]  status;

    modport source (output valid, output page_address, output ref_value,
                    output page_freed, output status, input ready);
    modport sink   (input valid, input page_address, input ref_value,
                    input page_freed, input status, output ready);
endinterface

interface rpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [39:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/rpa_ram.sv
// Simple dual-port synchronous RAM with registered read.
module rpa_ram #(
    parameter int DEPTH = rpa_pkg::NUM_PAGES_DEF,
    parameter int WIDTH = rpa_pkg::CNT_VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/rpa_cfg_regs.sv
// Region registers and page count of the configured region.
module rpa_cfg_regs #(
    parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BITS = rpa_pkg::PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [rpa_pkg::ADDR_W-1:0]     i_data,
    output rpa_pkg::t_region               o_region,
    output logic [$clog2(NUM_PAGES+1)-1:0] o_pages
);
    import rpa_pkg::*;

    localparam int CNT_W = $clog2(NUM_PAGES + 1);

    t_region           r_region;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W:0]   span_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region.base   <= BASE_RST;
            r_region.top    <= TOP_RST;
            r_region.usable <= USABLE_RST;
        end else if (i_we) begin
            case (i_index)
                CFG_BASE:   r_region.base   <= i_data;
                CFG_TOP:    r_region.top    <= i_data;
                CFG_USABLE: r_region.usable <= i_data;
                default:    ;
            endcase
        end
    end

    // whole pages in [base, top), capped at the table size
    always_comb begin
        span     = (r_region.top - r_region.base) >> PAGE_BITS;
        span_ext = {1'b0, span};
        if (r_region.top <= r_region.base) begin
            o_pages = '0;
        end else if (span_ext > (ADDR_W+1)'(NUM_PAGES)) begin
            o_pages = CNT_W'(NUM_PAGES);
        end else begin
            o_pages = span_ext[CNT_W-1:0];
        end
    end

    assign o_region = r_region;
endmodule

>>> rtl/core/refcounted_page_allocator_top.sv
// Top level of the refcounted page allocator: control, count and stack memories.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------
//  i_req    | in  | valid/ready   | func[1:0], address[39:0]
//  o_rsp    | out | valid/ready   | page_address[39:0], ref_value[7:0],
//           |     |               | page_freed, status[2:0]
//  i_cfg    | in  | valid/ready=1 | index[1:0], data[39:0]
//
// Each request is accepted in idle, then passes a check step with the memory
// read and an update step with the memory write-back; the registered read of
// the count and stack RAMs sets this. After reset the count RAM is swept to
// zero, one entry per cycle over all NUM_PAGES entries (32768 by default); no
// request is taken meanwhile, config writes are. A config write holds off
// requests while the never-used page pointer reloads. A full response register
// stalls the update stage; nothing is written until the result can be stored.
module refcounted_page_allocator_top #(
    parameter int NUM_PAGES = rpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BITS = rpa_pkg::PAGE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rpa_req_if.sink        i_req,
    rpa_rsp_if.source      o_rsp,
    rpa_cfg_if.sink        i_cfg
);
    import rpa_pkg::*;

    localparam int IDX_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CNT_W   = $clog2(NUM_PAGES + 1);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    localparam int SUM_W   =
        ((IDX_W + PAGE_BITS > ADDR_W) ? IDX_W + PAGE_BITS : ADDR_W) + 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // control
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic               r_recalc;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0]   r_untouched, n_untouched;
    logic               r_rsp_valid, n_rsp_valid;

    // request and check-stage results
    t_func             r_func;
    logic [ADDR_W-1:0] r_addr;
    logic              r_bad;
    logic              r_none;
    logic              r_from_stack;
    logic [IDX_W-1:0]  r_idx;
    t_rsp              r_rsp, n_rsp;

    // config
    t_region          region;
    logic [CNT_W-1:0] region_pages;
    logic             cfg_we;

    // check stage
    logic              req_fire;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W:0]   idx_ext;
    logic              in_tab;
    logic              free_ok;
    logic [IDX_W-1:0]  tbl_idx;
    logic [IDX_W-1:0]  untouched_m1;
    logic [SUM_W-1:0]  untouched_addr;
    logic              untouched_ok;
    logic [DEPTH_W-1:0] depth_m1;

    // update stage
    logic              commit;
    logic [IDX_W-1:0]  alloc_idx;
    logic [SUM_W-1:0]  alloc_addr;
    logic [CNT_VAL_W-1:0] cnt_dec;
    logic [CNT_VAL_W-1:0] cnt_inc;

    // memory ports
    logic                 cnt_we, upd_cnt_we;
    logic [IDX_W-1:0]     cnt_waddr, upd_cnt_addr;
    logic [CNT_VAL_W-1:0] cnt_wdata, upd_cnt_data;
    logic                 cnt_re;
    logic [CNT_VAL_W-1:0] cnt_rdata;
    logic                 stk_we;
    logic                 stk_re;
    logic [IDX_W-1:0]     stk_rdata;

    assign cfg_we      = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    rpa_cfg_regs #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BITS (PAGE_BITS)
    ) u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (cfg_we),
        .i_index  (i_cfg.index),
        .i_data   (i_cfg.data),
        .o_region (region),
        .o_pages  (region_pages)
    );

    assign i_req.ready = (r_state == S_IDLE) && !r_recalc;
    assign req_fire    = i_req.valid & i_req.ready;

    // ---------------- check stage: address decode, memory reads ----------------
    always_comb begin
        diff    = r_addr - region.base;
        idx_ext = {1'b0, diff >> PAGE_BITS};
        in_tab  = (r_addr >= region.base) && (r_addr < region.top) &&
                  (idx_ext < (ADDR_W+1)'(NUM_PAGES));
        tbl_idx = idx_ext[IDX_W-1:0];
        free_ok = in_tab && (r_addr[PAGE_BITS-1:0] == '0) &&
                  (r_addr >= region.usable);

        // next never-used page must still lie at or above usable_start
        untouched_m1   = IDX_W'(r_untouched - CNT_W'(1));
        untouched_addr = SUM_W'(region.base) + (SUM_W'(untouched_m1) << PAGE_BITS);
        untouched_ok   = (r_untouched != '0) &&
                         (untouched_addr >= SUM_W'(region.usable));

        depth_m1 = r_depth - DEPTH_W'(1);
    end

    assign cnt_re = (r_state == S_CHECK) && (r_func != FN_ALLOC);
    assign stk_re = (r_state == S_CHECK) && (r_func == FN_ALLOC) && (r_depth != '0);

    // ---------------- update stage: modify and write back ----------------
    assign commit  = (r_state == S_UPDATE) && (!r_rsp_valid || o_rsp.ready);
    assign cnt_dec = cnt_rdata - CNT_VAL_W'(1);
    assign cnt_inc = cnt_rdata + CNT_VAL_W'(1);

    always_comb begin
        alloc_idx    = r_from_stack ? stk_rdata : r_idx;
        alloc_addr   = SUM_W'(region.base) + (SUM_W'(alloc_idx) << PAGE_BITS);
        n_depth      = r_depth;
        n_untouched  = r_untouched;
        upd_cnt_we   = 1'b0;
        upd_cnt_addr = r_idx;
        upd_cnt_data = cnt_rdata;
        stk_we       = 1'b0;

        n_rsp.page_address = '0;
        n_rsp.ref_value    = '0;
        n_rsp.page_freed   = 1'b0;
        n_rsp.status       = ST_OK;

        case (r_func)
            FN_ALLOC: begin
                if (r_none) begin
                    n_rsp.status = ST_NO_PAGES;
                end else begin
                    upd_cnt_we         = 1'b1;
                    upd_cnt_addr       = alloc_idx;
                    upd_cnt_data       = CNT_VAL_W'(1);
                    n_rsp.page_address = alloc_addr[ADDR_W-1:0];
                    n_rsp.ref_value    = CNT_VAL_W'(1);
                    if (r_from_stack) begin
                        n_depth = depth_m1;
                    end else begin
                        n_untouched = r_untouched - CNT_W'(1);
                    end
                end
            end
            FN_FREE: begin
                if (r_bad) begin
                    n_rsp.status = ST_BAD_ADDR;
                end else if (cnt_rdata == '0) begin
                    n_rsp.status = ST_UNDERFLOW;
                end else begin
                    upd_cnt_we      = 1'b1;
                    upd_cnt_data    = cnt_dec;
                    n_rsp.ref_value = cnt_dec;
                    // push on last release; dropped when the stack is full
                    if (cnt_dec == '0 && r_depth < DEPTH_W'(NUM_PAGES)) begin
                        stk_we           = 1'b1;
                        n_depth          = r_depth + DEPTH_W'(1);
                        n_rsp.page_freed = 1'b1;
                    end
                end
            end
            FN_ADD_REF: begin
                if (r_bad) begin
                    n_rsp.status = ST_BAD_ADDR;
                end else if (cnt_rdata == CNT_MAX) begin
                    n_rsp.status    = ST_SATURATED;
                    n_rsp.ref_value = CNT_MAX;
                end else begin
                    upd_cnt_we      = 1'b1;
                    upd_cnt_data    = cnt_inc;
                    n_rsp.ref_value = cnt_inc;
                end
            end
            FN_READ: begin
                if (r_bad) begin
                    n_rsp.status = ST_BAD_ADDR;
                end else begin
                    n_rsp.ref_value = cnt_rdata;
                end
            end
            default: ;
        endcase

        if (!commit) begin
            n_depth     = r_depth;
            n_untouched = r_untouched;
            upd_cnt_we  = 1'b0;
            stk_we      = 1'b0;
        end
        // reload of the never-used pointer after a config write
        if (r_recalc) begin
            n_untouched = region_pages;
        end
    end

    // count RAM write port: clearing sweep after reset, else the update stage
    always_comb begin
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_idx;
            cnt_wdata = '0;
        end else begin
            cnt_we    = upd_cnt_we;
            cnt_waddr = upd_cnt_addr;
            cnt_wdata = upd_cnt_data;
        end
    end

    rpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (CNT_VAL_W)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (tbl_idx),
        .o_rdata (cnt_rdata)
    );

    rpa_ram #(
        .DEPTH (NUM_PAGES),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[IDX_W-1:0]),
        .i_wdata (r_idx),
        .i_re    (stk_re),
        .i_raddr (depth_m1[IDX_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // ---------------- sequencing ----------------
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_rsp_valid = r_rsp_valid;
        if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == IDX_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_recalc    <= 1'b1;
            r_depth     <= '0;
            r_untouched <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_recalc    <= cfg_we;
            r_depth     <= n_depth;
            r_untouched <= n_untouched;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func <= t_func'(i_req.func);
            r_addr <= i_req.address;
        end
        if (r_state == S_CHECK) begin
            r_bad        <= (r_func == FN_FREE) ? !free_ok : !in_tab;
            r_from_stack <= (r_depth != '0);
            r_none       <= (r_depth == '0) && !untouched_ok;
            r_idx        <= (r_func == FN_ALLOC) ? untouched_m1 : tbl_idx;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.page_address = r_rsp.page_address;
    assign o_rsp.ref_value    = r_rsp.ref_value;
    assign o_rsp.page_freed   = r_rsp.page_freed;
    assign o_rsp.status       = r_rsp.status;
endmodule
